/* rtl/tns_pkg.sv */
// tns_pkg: shared types, constants and helpers of the tone note sequencer.
// Depends on nothing; the RTL files refer to it by scoped names, the bench imports it.

package tns_pkg;

  // Queue geometry: the ring holds at most QUEUE_DEPTH-1 notes
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = 4;

  // Word field widths
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned PWM_W  = 16;

  // Configuration registers
  localparam int unsigned CLKHZ_W = 28;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned CFG_W   = 28;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CLKHZ_W-1:0] CLKHZ_RST = 28'd170000000;
  localparam logic [DUTY_W-1:0]  DUTY_RST  = 8'd10;

  // Shared divider geometry
  localparam int unsigned DIVIDEND_W = CLKHZ_W;
  localparam int unsigned DIVISOR_W  = FREQ_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [QCNT_W-1:0] qcount_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_STOP = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_CLK = 1'b0,
    REG_DUTY_DIV  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [FREQ_W-1:0] note_frequency;
    logic [DUR_W-1:0]  note_duration;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic [PWM_W-1:0]  pwm_period;
    logic [PWM_W-1:0]  pwm_compare;
    logic              playing;
    logic [QCNT_W-1:0] queue_count;
  } out_word_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic ptr_t ptr_next(ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // Notes in the ring, reduced to the reported width
  function automatic qcount_t queue_fill(ptr_t tail, ptr_t head);
    logic [PTR_W:0] wrap;
    logic [PTR_W:0] fill;
    wrap = (tail < head) ? (PTR_W + 1)'(QUEUE_DEPTH) : '0;
    fill = {1'b0, tail} + wrap - {1'b0, head};
    return qcount_t'(fill);
  endfunction

endpackage

/* rtl/tns_divider.sv */
// tns_divider: restoring divider, one quotient bit per cycle, shared by the
// period and compare calculations. Depends on tns_pkg.

module tns_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tns_pkg::div_req_t req_i,
  output tns_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [tns_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [tns_pkg::DIVIDEND_W-1:0]      quo_q;
  logic [tns_pkg::DIVISOR_W:0]         rem_q;
  logic [tns_pkg::DIVISOR_W-1:0]       dvs_q;
  logic [tns_pkg::DIVISOR_W:0]         rem_sh;
  logic [tns_pkg::DIVISOR_W:0]         dvs_ext;
  logic                                ge;

  assign rem_sh  = {rem_q[tns_pkg::DIVISOR_W-1:0], quo_q[tns_pkg::DIVIDEND_W-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = (rem_sh >= dvs_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= tns_pkg::DIV_CNT_W'(tns_pkg::DIVIDEND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - tns_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[tns_pkg::DIVIDEND_W-2:0], ge};
      rem_q <= ge ? (rem_sh - dvs_ext) : rem_sh;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/tone_note_sequencer_unit.sv */
// tone_note_sequencer_unit: note ring queue, tone sequencer and result register.
// Depends on tns_pkg and tns_divider.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   in       | in_valid_i / in_ready_o   | in_word_i  (tns_pkg::in_word_t)
//   out      | out_valid_o / out_ready_i | out_word_o (tns_pkg::out_word_t)
//   config   | cfg_we_i, no wait         | cfg_idx_i, cfg_data_i
//
// Add, stop, unused requests and ticks on an empty queue go from accept
// straight to the result register.
// A tick on a live queue loads the tone when playback starts and again when the
// head moves on; each tone load is two 28-step passes through the shared divider.
// Reset clears pointers, tone state and handshakes; the note stores hold
// garbage until written. A stalled result waits in the output register
// while the next word is accepted.

module tone_note_sequencer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tns_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tns_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [tns_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tns_pkg::CFG_W-1:0]         cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_READ   = 9'b000000010,
    S_PSTART = 9'b000000100,
    S_PWAIT  = 9'b000001000,
    S_CSTART = 9'b000010000,
    S_CWAIT  = 9'b000100000,
    S_ADV    = 9'b001000000,
    S_WAIT   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  tns_pkg::ptr_t                  head_q, head_d;
  tns_pkg::ptr_t                  tail_q, tail_d;
  logic                           playing_q, playing_d;
  logic [tns_pkg::PWM_W-1:0]      period_q, period_d;
  logic [tns_pkg::PWM_W-1:0]      compare_q, compare_d;
  logic                           acc_q, acc_d;
  logic                           dec_zero_q, dec_zero_d;
  logic                           after_adv_q, after_adv_d;
  logic                           fzero_q, fzero_d;
  logic [tns_pkg::CLKHZ_W-1:0]    clk_hz_q;
  logic [tns_pkg::DUTY_W-1:0]     duty_q;
  logic                           out_valid_q;
  tns_pkg::out_word_t             out_q;
  logic                           out_load;

  // Note stores
  logic [tns_pkg::FREQ_W-1:0]     freq_mem  [tns_pkg::QUEUE_DEPTH];
  logic [tns_pkg::DUR_W-1:0]      ticks_mem [tns_pkg::QUEUE_DEPTH];
  logic [tns_pkg::FREQ_W-1:0]     freq_rd_q;
  logic [tns_pkg::DUR_W-1:0]      ticks_rd_q;
  logic                           freq_we;
  logic                           ticks_we;
  tns_pkg::ptr_t                  ticks_waddr;
  logic [tns_pkg::DUR_W-1:0]      ticks_wdata;
  logic [tns_pkg::DUR_W-1:0]      ticks_dec;

  tns_pkg::div_req_t              div_req;
  tns_pkg::div_rsp_t              div_rsp;

  logic                           in_fire;
  logic                           add_ok;
  tns_pkg::ptr_t                  head_nx;
  logic [tns_pkg::PWM_W-1:0]      period_sat;
  logic [tns_pkg::DUTY_W-1:0]     duty_eff;

  tns_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign add_ok     = (in_word_i.note_frequency != '0) && (in_word_i.note_duration != '0) &&
                      (tns_pkg::ptr_next(tail_q) != head_q);
  assign head_nx    = tns_pkg::ptr_next(head_q);
  assign ticks_dec  = ticks_rd_q - tns_pkg::DUR_W'(1);
  assign period_sat = (|div_rsp.quotient[tns_pkg::DIVIDEND_W-1:tns_pkg::PWM_W]) ?
                      '1 : div_rsp.quotient[tns_pkg::PWM_W-1:0];
  assign duty_eff   = (duty_q == '0) ? tns_pkg::DUTY_W'(1) : duty_q;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    playing_d   = playing_q;
    period_d    = period_q;
    compare_d   = compare_q;
    acc_d       = acc_q;
    dec_zero_d  = dec_zero_q;
    after_adv_d = after_adv_q;
    fzero_d     = fzero_q;
    freq_we     = 1'b0;
    ticks_we    = 1'b0;
    ticks_waddr = tail_q;
    ticks_wdata = in_word_i.note_duration;
    div_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          acc_d   = 1'b0;
          state_d = S_OUT;
          case (in_word_i.req_type)
            tns_pkg::REQ_ADD: begin
              if (add_ok) begin
                freq_we  = 1'b1;
                ticks_we = 1'b1;
                tail_d   = tns_pkg::ptr_next(tail_q);
                acc_d    = 1'b1;
              end
            end
            tns_pkg::REQ_TICK: begin
              if (head_q != tail_q) begin
                state_d = S_READ;
              end
            end
            tns_pkg::REQ_STOP: begin
              head_d    = '0;
              tail_d    = '0;
              compare_d = '0;
              playing_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // Count the head note down; load its tone first if playback starts
        ticks_we    = 1'b1;
        ticks_waddr = head_q;
        ticks_wdata = ticks_dec;
        dec_zero_d  = (ticks_dec == '0);
        after_adv_d = 1'b0;
        if (!playing_q) begin
          playing_d = 1'b1;
          state_d   = S_PSTART;
        end else begin
          state_d = S_ADV;
        end
      end
      S_PSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = clk_hz_q;
        div_req.divisor  = {freq_rd_q, 1'b0};
        fzero_d          = (freq_rd_q == '0);
        state_d          = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          period_d = fzero_q ? '0 : period_sat;
          state_d  = S_CSTART;
        end
      end
      S_CSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = tns_pkg::DIVIDEND_W'(period_q);
        div_req.divisor  = tns_pkg::DIVISOR_W'(duty_eff);
        state_d          = S_CWAIT;
      end
      S_CWAIT: begin
        if (div_rsp.done) begin
          compare_d = div_rsp.quotient[tns_pkg::PWM_W-1:0];
          state_d   = after_adv_q ? S_OUT : S_ADV;
        end
      end
      S_ADV: begin
        state_d = S_OUT;
        if (dec_zero_q) begin
          if (head_nx == tail_q) begin
            head_d    = '0;
            tail_d    = '0;
            compare_d = '0;
            playing_d = 1'b0;
          end else begin
            head_d      = head_nx;
            after_adv_d = 1'b1;
            state_d     = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // let the store read follow the new head
        state_d = S_PSTART;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      playing_q   <= 1'b0;
      period_q    <= '0;
      compare_q   <= '0;
      acc_q       <= 1'b0;
      dec_zero_q  <= 1'b0;
      after_adv_q <= 1'b0;
      fzero_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clk_hz_q    <= tns_pkg::CLKHZ_RST;
      duty_q      <= tns_pkg::DUTY_RST;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      playing_q   <= playing_d;
      period_q    <= period_d;
      compare_q   <= compare_d;
      acc_q       <= acc_d;
      dec_zero_q  <= dec_zero_d;
      after_adv_q <= after_adv_d;
      fzero_q     <= fzero_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tns_pkg::REG_TIMER_CLK: clk_hz_q <= cfg_data_i[tns_pkg::CLKHZ_W-1:0];
          tns_pkg::REG_DUTY_DIV:  duty_q   <= cfg_data_i[tns_pkg::DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.accepted    <= acc_q;
      out_q.pwm_period  <= period_q;
      out_q.pwm_compare <= compare_q;
      out_q.playing     <= playing_q;
      out_q.queue_count <= tns_pkg::queue_fill(tail_q, head_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[tail_q] <= in_word_i.note_frequency;
    end
    freq_rd_q <= freq_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (ticks_we) begin
      ticks_mem[ticks_waddr] <= ticks_wdata;
    end
    ticks_rd_q <= ticks_mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/tns_checker.sv */
// tns_checker: port-level checks of the tone note sequencer, bound to the top.
// Depends on tns_pkg and tone_note_sequencer_unit.

module tns_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input tns_pkg::out_word_t            out_word_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // one word at a time: no accept right after an accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous word in flight");

  a_silent_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.playing |-> out_word_o.pwm_compare == '0)
    else $error("nonzero compare while silent");

  a_play_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.playing |-> out_word_o.queue_count != '0)
    else $error("playing with an empty queue");

  a_acc_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.accepted |-> out_word_o.queue_count != '0)
    else $error("stored note missing from queue count");

endmodule

bind tone_note_sequencer_unit tns_checker u_tns_checker (.*);

/* tb/tb_top.sv */
// tb_top: self-checking bench for tone_note_sequencer_unit, the note queue and PWM tone unit.
// Depends on tns_pkg and the unit's RTL; an internal predictor tracks the queue and tone state.

module tb_top;
  import tns_pkg::*;

  localparam int unsigned RING          = QUEUE_DEPTH;
  localparam int unsigned SETTLE_CYCLES = 130;
  localparam int unsigned RANDOM_WORDS  = 1550;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  tone_note_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Predicted unit state
  logic [FREQ_W-1:0]  note_freq [RING];
  logic [DUR_W-1:0]   note_ticks [RING];
  ptr_t               head_ix = '0;
  ptr_t               tail_ix = '0;
  logic               sounding = 1'b0;
  logic [PWM_W-1:0]   period_q = '0;
  logic [PWM_W-1:0]   compare_q = '0;
  logic [CLKHZ_W-1:0] clk_hz_cfg = CLKHZ_RST;
  logic [DUTY_W-1:0]  duty_cfg = DUTY_RST;

  in_word_t  pending_words [$];
  out_word_t expected_status [$];
  out_word_t want;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned status_checked = 0;
  int unsigned notes_queued   = 0;
  int unsigned adds_rejected  = 0;
  int unsigned ticks_played   = 0;
  int unsigned phases_run     = 0;

  function automatic ptr_t ring_step(ptr_t p);
    return ptr_t'((p + 1) % RING);
  endfunction

  function automatic void load_tone();
    int unsigned f;
    int unsigned p;
    int unsigned d;
    f = note_freq[head_ix];
    p = 0;
    d = (duty_cfg != 0) ? duty_cfg : 1;
    if (f != 0) p = clk_hz_cfg / (2 * f);
    if (p > 65535) p = 65535;
    period_q  = PWM_W'(p);
    compare_q = PWM_W'(p / d);
  endfunction

  function automatic void go_silent();
    head_ix   = '0;
    tail_ix   = '0;
    compare_q = '0;
    sounding  = 1'b0;
  endfunction

  function automatic out_word_t predict_status(in_word_t w);
    out_word_t r;
    ptr_t      h;
    r.accepted = 1'b0;
    case (req_e'(w.req_type))
      REQ_ADD: begin
        if (w.note_frequency != 0 && w.note_duration != 0 && ring_step(tail_ix) != head_ix) begin
          note_freq[tail_ix]  = w.note_frequency;
          note_ticks[tail_ix] = w.note_duration;
          tail_ix    = ring_step(tail_ix);
          r.accepted = 1'b1;
          notes_queued++;
        end else begin
          adds_rejected++;
        end
      end
      REQ_TICK: begin
        if (head_ix != tail_ix) begin
          h = head_ix;
          if (!sounding) begin
            sounding = 1'b1;
            load_tone();
          end
          note_ticks[h] = note_ticks[h] - 1'b1;
          // advance to the next note once the head has run out
          if (note_ticks[h] == 0) begin
            head_ix = ring_step(head_ix);
            if (head_ix == tail_ix) go_silent();
            else load_tone();
          end
          ticks_played++;
        end
      end
      REQ_STOP: go_silent();
      default: ;
    endcase
    r.pwm_period  = period_q;
    r.pwm_compare = compare_q;
    r.playing     = sounding;
    r.queue_count = qcount_t'((tail_ix + RING - head_ix) % RING);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned exp_val);
    $display("MISMATCH %s at word %0d: got %0d, expected %0d",
             what, status_checked, got, exp_val);
    mismatches++;
  endtask

  // Driver: present queued words, hold each until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(predict_status(in_word));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          flag_mismatch("unexpected result word", 1, 0);
        end else begin
          want = expected_status.pop_front();
          if (out_word.accepted !== want.accepted)
            flag_mismatch("accepted", out_word.accepted, want.accepted);
          if (out_word.pwm_period !== want.pwm_period)
            flag_mismatch("pwm_period", out_word.pwm_period, want.pwm_period);
          if (out_word.pwm_compare !== want.pwm_compare)
            flag_mismatch("pwm_compare", out_word.pwm_compare, want.pwm_compare);
          if (out_word.playing !== want.playing)
            flag_mismatch("playing", out_word.playing, want.playing);
          if (out_word.queue_count !== want.queue_count)
            flag_mismatch("queue_count", out_word.queue_count, want.queue_count);
        end
        status_checked++;
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  function automatic in_word_t note_word(req_e req, int unsigned f, int unsigned d);
    in_word_t w;
    w.req_type       = req;
    w.note_frequency = FREQ_W'(f);
    w.note_duration  = DUR_W'(d);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned f;
    int unsigned d;
    pick = $urandom_range(99, 0);
    case ($urandom_range(19, 0))
      0:       f = 0;
      1, 2:    f = $urandom_range(10, 1);
      default: f = $urandom_range(65535, 1);
    endcase
    // keep most notes short so playback advances through the ring
    case ($urandom_range(19, 0))
      0:          d = 0;
      1:          d = $urandom_range(65535, 0);
      2, 3, 4, 5: d = $urandom_range(40, 5);
      default:    d = $urandom_range(4, 1);
    endcase
    if (pick < 40)      w = note_word(REQ_ADD, f, d);
    else if (pick < 85) w = note_word(REQ_TICK, f, d);
    else if (pick < 92) w = note_word(REQ_STOP, f, d);
    else if (pick < 96) w = note_word(REQ_NOP, f, d);
    else                w = in_word_t'({$urandom, $urandom});
    return w;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == REG_TIMER_CLK) clk_hz_cfg = data[CLKHZ_W-1:0];
    else duty_cfg = data[DUTY_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_words.push_back(random_word());
    drain_all();
    phases_run++;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue requests, rejects, saturation, playback, queue full
    pending_words.push_back(note_word(REQ_TICK, 0, 0));
    pending_words.push_back(note_word(REQ_NOP, 65535, 65535));
    pending_words.push_back(note_word(REQ_STOP, 0, 0));
    pending_words.push_back(note_word(REQ_ADD, 0, 5));
    pending_words.push_back(note_word(REQ_ADD, 100, 0));
    pending_words.push_back(note_word(REQ_ADD, 1, 2));
    pending_words.push_back(note_word(REQ_ADD, 65535, 1));
    pending_words.push_back(note_word(REQ_TICK, 0, 0));
    pending_words.push_back(note_word(REQ_ADD, 440, 65535));
    pending_words.push_back(note_word(REQ_TICK, 0, 0));
    pending_words.push_back(note_word(REQ_TICK, 0, 0));
    // fill the ring until the last add bounces
    repeat (15) pending_words.push_back(note_word(REQ_ADD, $urandom_range(65535, 1),
                                                  $urandom_range(65535, 1)));
    pending_words.push_back(note_word(REQ_STOP, 0, 0));
    run_phase(0, 0, 300);

    write_reg(REG_TIMER_CLK, CFG_W'(268435455));
    write_reg(REG_DUTY_DIV, CFG_W'(255));
    run_phase(79, 0, 300);

    write_reg(REG_TIMER_CLK, CFG_W'(1));
    write_reg(REG_DUTY_DIV, CFG_W'(1));
    run_phase(0, 79, 300);

    // zero clock gives a zero period; zero divisor acts as one
    write_reg(REG_TIMER_CLK, CFG_W'(0));
    write_reg(REG_DUTY_DIV, CFG_W'(0));
    run_phase(12, 12, 250);

    write_reg(REG_TIMER_CLK, CFG_W'($urandom_range(268435455, 1)));
    write_reg(REG_DUTY_DIV, CFG_W'($urandom_range(255, 1)));
    run_phase(0, 0, 200);

    write_reg(REG_TIMER_CLK, CFG_W'(CLKHZ_RST));
    write_reg(REG_DUTY_DIV, CFG_W'($urandom_range(255, 0)));
    run_phase(12, 12, RANDOM_WORDS - 1350);

    $display("Checked %0d result words over %0d phases and 6 register settings.",
             status_checked, phases_run);
    $display("Notes queued %0d, adds rejected %0d, ticks on a live queue %0d.",
             notes_queued, adds_rejected, ticks_played);
    if (mismatches == 0) begin
      $display("tone_note_sequencer_unit verification clean");
    end else begin
      $display("tone_note_sequencer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Timeout with %0d result words outstanding", expected_status.size());
    $display("tone_note_sequencer_unit verification failed");
    $finish;
  end

endmodule
